>>> rtl/pst_pkg.sv
package pst_pkg;

  localparam int POOL_SLOTS = 8;
  localparam int SLOT_W     = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam int KEY_W      = 31;
  localparam int PIN_W      = 16;
  localparam int CNT_W      = 7;
  localparam int EVT_W      = 32;
  localparam int IDX_W      = 6;

  localparam logic [PIN_W-1:0] PIN_MAX = '1;

  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_UNLOAD = 2'd1;
  localparam logic [1:0] CMD_PROBE  = 2'd2;

  localparam logic [2:0] ST_HIT      = 3'd0;
  localparam logic [2:0] ST_INSERTED = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_UNPINNED = 3'd3;
  localparam logic [2:0] ST_RELEASED = 3'd4;
  localparam logic [2:0] ST_NOTFOUND = 3'd5;
  localparam logic [2:0] ST_PRESENT  = 3'd6;
  localparam logic [2:0] ST_ABSENT   = 3'd7;

  typedef struct packed {
    logic [1:0]       command;
    logic [KEY_W-1:0] key_id;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [IDX_W-1:0] slot_index;
    logic [PIN_W-1:0] pins_after;
    logic [CNT_W-1:0] usage_now;
    logic [CNT_W-1:0] usage_peak;
    logic [EVT_W-1:0] loads_total;
    logic [EVT_W-1:0] releases_total;
    logic [EVT_W-1:0] blocked_total;
  } out_item_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] hit_idx;
    logic              free;
    logic [SLOT_W-1:0] free_idx;
  } lookup_t;

endpackage

>>> rtl/pst_lookup.sv
module pst_lookup (
  input  logic [pst_pkg::KEY_W-1:0]      key,
  input  logic [pst_pkg::POOL_SLOTS-1:0] valid,
  input  logic [pst_pkg::KEY_W-1:0]      keys [pst_pkg::POOL_SLOTS],
  output pst_pkg::lookup_t               res
);
  import pst_pkg::*;

  // Scan from the top down so the lowest matching / free slot wins.
  always_comb begin
    res = '0;
    for (int i = POOL_SLOTS - 1; i >= 0; i--) begin
      if (valid[i] && (keys[i] == key)) begin
        res.hit     = 1'b1;
        res.hit_idx = SLOT_W'(i);
      end
      if (!valid[i]) begin
        res.free     = 1'b1;
        res.free_idx = SLOT_W'(i);
      end
    end
  end

endmodule

>>> rtl/pinned_slot_table.sv
// Pinned slot table: a small table of keyed slots, each with a 16-bit pin
// count. A load of a held key adds a pin (saturating at 65535); a load of a
// new key takes the lowest free slot with one pin, or reports full and counts
// a blocked event when no slot is free, leaving the caller to retry. An unload
// drops one pin and releases the slot at zero; an unknown key reports not
// found. A probe (command two, and also the unused command three) reports
// presence. Every item yields exactly one result carrying the occupancy, the
// peak occupancy and three wrapping event counters. The block takes one item
// per clock cycle unless stalled by output back-pressure: the item is held in
// an input register, all slots are compared against its key in parallel, the
// table is updated and the result is captured in an output register. The next
// item sees the table as left by the previous one without any bubble. Output
// back-pressure stalls the input only when both the input and output registers
// are full. After reset the table is empty and all counters are zero; no
// clearing pass is needed.
module pinned_slot_table (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pst_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output pst_pkg::out_item_t out_item
);
  import pst_pkg::*;

  // Input register
  logic     s1_valid_r;
  in_item_t s1_item_r;

  // Slot table
  logic [POOL_SLOTS-1:0] slot_valid_r;
  logic [KEY_W-1:0]      slot_key_r  [POOL_SLOTS];
  logic [PIN_W-1:0]      slot_pins_r [POOL_SLOTS];

  // Occupancy and event counters
  logic [CNT_W-1:0] occ_r,  occ_nxt;
  logic [CNT_W-1:0] peak_r, peak_nxt;
  logic [EVT_W-1:0] ins_r,  ins_nxt;
  logic [EVT_W-1:0] rel_r,  rel_nxt;
  logic [EVT_W-1:0] blk_r,  blk_nxt;

  // Result register
  logic      out_valid_r;
  out_item_t out_item_r, out_item_nxt;

  // Slot update request for this cycle
  logic              upd_en;
  logic [SLOT_W-1:0] upd_idx;
  logic              upd_valid;
  logic              upd_key_we;
  logic [PIN_W-1:0]  upd_pins;

  lookup_t          lk;
  logic [PIN_W-1:0] hit_pins;
  logic             advance;

  // Advance the held item whenever the result register is free or draining.
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  pst_lookup u_lookup (
    .key   (s1_item_r.key_id),
    .valid (slot_valid_r),
    .keys  (slot_key_r),
    .res   (lk)
  );

  assign hit_pins = slot_pins_r[lk.hit_idx];

  always_comb begin
    occ_nxt    = occ_r;
    peak_nxt   = peak_r;
    ins_nxt    = ins_r;
    rel_nxt    = rel_r;
    blk_nxt    = blk_r;
    upd_en     = 1'b0;
    upd_idx    = lk.hit_idx;
    upd_valid  = 1'b1;
    upd_key_we = 1'b0;
    upd_pins   = hit_pins;

    out_item_nxt = '0;

    case (s1_item_r.command)
      CMD_LOAD: begin
        if (lk.hit) begin
          // Add a pin, saturating at the top.
          upd_en   = 1'b1;
          upd_pins = (hit_pins == PIN_MAX) ? hit_pins : hit_pins + PIN_W'(1);
          out_item_nxt.status     = ST_HIT;
          out_item_nxt.slot_index = IDX_W'(lk.hit_idx);
          out_item_nxt.pins_after = upd_pins;
        end else if (lk.free) begin
          upd_en     = 1'b1;
          upd_idx    = lk.free_idx;
          upd_key_we = 1'b1;
          upd_pins   = PIN_W'(1);
          ins_nxt    = ins_r + EVT_W'(1);
          occ_nxt    = occ_r + CNT_W'(1);
          if (occ_nxt > peak_r) begin
            peak_nxt = occ_nxt;
          end
          out_item_nxt.status     = ST_INSERTED;
          out_item_nxt.slot_index = IDX_W'(lk.free_idx);
          out_item_nxt.pins_after = PIN_W'(1);
        end else begin
          blk_nxt             = blk_r + EVT_W'(1);
          out_item_nxt.status = ST_FULL;
        end
      end
      CMD_UNLOAD: begin
        if (!lk.hit) begin
          out_item_nxt.status = ST_NOTFOUND;
        end else begin
          upd_en                  = 1'b1;
          out_item_nxt.slot_index = IDX_W'(lk.hit_idx);
          if (hit_pins <= PIN_W'(1)) begin
            // Last pin gone: release the slot.
            upd_valid = 1'b0;
            upd_pins  = '0;
            rel_nxt   = rel_r + EVT_W'(1);
            if (occ_r != '0) begin
              occ_nxt = occ_r - CNT_W'(1);
            end
            out_item_nxt.status     = ST_RELEASED;
            out_item_nxt.pins_after = '0;
          end else begin
            upd_pins                = hit_pins - PIN_W'(1);
            out_item_nxt.status     = ST_UNPINNED;
            out_item_nxt.pins_after = upd_pins;
          end
        end
      end
      default: begin
        // Probe; the unused command code behaves the same.
        if (lk.hit) begin
          out_item_nxt.status     = ST_PRESENT;
          out_item_nxt.slot_index = IDX_W'(lk.hit_idx);
          out_item_nxt.pins_after = hit_pins;
        end else begin
          out_item_nxt.status = ST_ABSENT;
        end
      end
    endcase

    out_item_nxt.usage_now      = occ_nxt;
    out_item_nxt.usage_peak     = peak_nxt;
    out_item_nxt.loads_total    = ins_nxt;
    out_item_nxt.releases_total = rel_nxt;
    out_item_nxt.blocked_total  = blk_nxt;
  end

  // Control, valid bits, pin counts and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      slot_valid_r <= '0;
      occ_r        <= '0;
      peak_r       <= '0;
      ins_r        <= '0;
      rel_r        <= '0;
      blk_r        <= '0;
      for (int i = 0; i < POOL_SLOTS; i++) begin
        slot_pins_r[i] <= '0;
      end
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      out_valid_r <= advance || (out_valid_r && !out_ready);
      if (advance) begin
        occ_r  <= occ_nxt;
        peak_r <= peak_nxt;
        ins_r  <= ins_nxt;
        rel_r  <= rel_nxt;
        blk_r  <= blk_nxt;
        if (upd_en) begin
          slot_valid_r[upd_idx] <= upd_valid;
          slot_pins_r[upd_idx]  <= upd_pins;
        end
      end
    end
  end

  // Payload registers: keys, held item and result
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_item;
    end
    if (advance) begin
      out_item_r <= out_item_nxt;
      if (upd_en && upd_key_we) begin
        slot_key_r[upd_idx] <= s1_item_r.key_id;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

>>> rtl/pst_checker.sv
module pst_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input pst_pkg::in_item_t  in_item,
  input logic               out_valid,
  input logic               out_ready,
  input pst_pkg::out_item_t out_item
);
  import pst_pkg::*;

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_item))
    else $error("input item changed while waiting");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  a_peak_ge_now: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.usage_peak >= out_item.usage_now)
    else $error("peak below current usage");

  a_full_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status == ST_FULL |->
      out_item.slot_index == '0 && out_item.pins_after == '0 &&
      out_item.usage_now == CNT_W'(POOL_SLOTS))
    else $error("full result with wrong fields");

  a_pins_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status == ST_RELEASED || out_item.status == ST_ABSENT ||
                  out_item.status == ST_NOTFOUND) |-> out_item.pins_after == '0)
    else $error("pins reported on empty slot");

endmodule

bind pinned_slot_table pst_checker u_pst_checker (.*);
